@@ hw/rtl/radf_pkg.sv @@
// Shared constants, request type and CRC-8 update for the register datagram framer.
package radf_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'h05;
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    localparam int ADDR_W   = 7;
    localparam int DATA_W   = 32;
    localparam int S_TDATA_W = 40;
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 3;

    localparam logic [IDX_W-1:0] IDX_SYNC  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_NODE  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_ADDR  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_DATA3 = 3'd3;
    localparam logic [IDX_W-1:0] IDX_DATA2 = 3'd4;
    localparam logic [IDX_W-1:0] IDX_DATA1 = 3'd5;
    localparam logic [IDX_W-1:0] IDX_DATA0 = 3'd6;
    localparam logic [IDX_W-1:0] IDX_CRC_W = 3'd7;

    localparam logic [IDX_W-1:0] READ_LAST_IDX  = 3'd3;
    localparam logic [IDX_W-1:0] WRITE_LAST_IDX = 3'd7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic              is_write;
        logic [BYTE_W-1:0] addr_byte;
        logic [DATA_W-1:0] data;
    } radf_req_t;

    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] data_byte);
        logic [BYTE_W-1:0] c;
        logic              fb;
        c = crc;
        for (int j = 0; j < BYTE_W; j++)
        begin
            fb = c[BYTE_W-1] ^ data_byte[j];
            c  = {c[BYTE_W-2:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/radf_front.sv @@
// Request intake stage: accepts a request transaction and classifies it as read or write.
module radf_front
    import radf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // target_reg[6:0], write_data[38:7], zero[39]
    input  logic                 s_axis_tuser,  // req_type
    output logic                 req_valid,
    input  logic                 req_ready,
    output radf_req_t            req
);

    logic      valid_reg;
    logic      valid_next;
    radf_req_t req_reg;
    radf_req_t req_next;
    logic      s_accept;

    assign s_axis_tready = !valid_reg || req_ready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign req_valid     = valid_reg;
    assign req           = req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        req_next   = req_reg;
        if (s_accept)
        begin
            valid_next         = 1'b1;
            req_next.is_write  = s_axis_tuser;
            req_next.addr_byte = {1'b0, s_axis_tdata[ADDR_W-1:0]}
                                 | (s_axis_tuser ? WRITE_FLAG : '0);
            req_next.data      = s_axis_tuser ? s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W] : '0;
        end
        else if (req_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

endmodule

@@ hw/rtl/radf_queue.sv @@
// Short request queue between the intake stage and the datagram serializer.
module radf_queue
    import radf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  radf_req_t push_entry,
    output logic      pop_valid,
    input  logic      pop_ready,
    output radf_req_t pop_entry
);

    localparam logic [QPTR_W:0]   DEPTH_C   = (QPTR_W+1)'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] LAST_PTR  = QPTR_W'(QUEUE_DEPTH - 1);

    radf_req_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != DEPTH_C;
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ hw/rtl/radf_back.sv @@
// Datagram serializer: emits the bytes of one request with a running CRC-8.
module radf_back
    import radf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  radf_req_t         req,
    input  logic [BYTE_W-1:0] node_address,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,  // out_byte[7:0]
    output logic              m_axis_tlast   // last_byte
);

    logic              busy_reg;
    logic              busy_next;
    radf_req_t         cur_reg;
    radf_req_t         cur_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [BYTE_W-1:0] crc_reg;
    logic [BYTE_W-1:0] crc_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_byte_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic              out_free;
    logic              advance;
    logic              at_last;
    logic              load;
    logic [BYTE_W-1:0] field_byte;
    logic [BYTE_W-1:0] cur_byte;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign advance   = busy_reg && out_free;
    assign at_last   = idx_reg == (cur_reg.is_write ? WRITE_LAST_IDX : READ_LAST_IDX);
    assign req_ready = !busy_reg || (advance && at_last);
    assign load      = req_valid && req_ready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        unique case (idx_reg)
            IDX_SYNC:  field_byte = SYNC_BYTE;
            IDX_NODE:  field_byte = node_address;
            IDX_ADDR:  field_byte = cur_reg.addr_byte;
            IDX_DATA3: field_byte = cur_reg.data[31:24];
            IDX_DATA2: field_byte = cur_reg.data[23:16];
            IDX_DATA1: field_byte = cur_reg.data[15:8];
            IDX_DATA0: field_byte = cur_reg.data[7:0];
            IDX_CRC_W: field_byte = crc_reg;
            default:   field_byte = crc_reg;
        endcase
        cur_byte = at_last ? crc_reg : field_byte;
    end

    always_comb
    begin
        busy_next      = busy_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            out_last_next  = at_last;
            idx_next       = idx_reg + 1'b1;
            crc_next       = crc8_update(crc_reg, cur_byte);
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            busy_next = 1'b1;
            cur_next  = req;
            idx_next  = '0;
            crc_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        idx_reg      <= idx_next;
        crc_reg      <= crc_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

@@ hw/rtl/register_access_datagram_framer.sv @@
// Top level of the register access datagram framer.
//
// Input stream (s_axis): one register access request per transaction; tuser is
// the request type (1 = write, 0 = read), tdata carries the register address and
// the write value. Output stream (m_axis): the datagram bytes in transmit order,
// tlast on the closing CRC-8 byte. Configuration channel (cfg_*): the node
// address byte, always ready, to be written while no datagram is in flight.
//
// The first byte of a datagram reaches m_axis through the intake register, a queue
// entry, the serializer load register and the serializer output register.
// Throughput: one byte per cycle while tready stays high; a write datagram has 8 bytes,
// a read 4, and the serializer picks up the next queued request in the cycle it emits a
// CRC byte, so datagrams follow each other without a gap.
//
// Reset empties the intake stage, the queue and the serializer and clears the
// node address to zero. When the receiver holds tready low, the current byte
// holds on m_axis; the serializer stops, the queue fills, and s_axis_tready
// drops once the intake stage and both queue entries are taken.
module register_access_datagram_framer
    import radf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // target_reg[6:0], write_data[38:7], zero[39]
    input  logic                 s_axis_tuser,  // req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [BYTE_W-1:0]    m_axis_tdata,  // out_byte[7:0]
    output logic                 m_axis_tlast,  // last_byte
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [BYTE_W-1:0]    cfg_data       // node_address[7:0]
);

    logic [BYTE_W-1:0] node_addr_reg;
    logic [BYTE_W-1:0] node_addr_next;

    logic      front_valid;
    logic      front_ready;
    radf_req_t front_req;
    logic      queue_valid;
    logic      queue_ready;
    radf_req_t queue_req;

    assign cfg_ready      = 1'b1;
    assign node_addr_next = (cfg_valid && cfg_ready) ? cfg_data : node_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_addr_reg <= '0;
        end
        else
        begin
            node_addr_reg <= node_addr_next;
        end
    end

    radf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .req_valid     (front_valid),
        .req_ready     (front_ready),
        .req           (front_req)
    );

    radf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_entry (front_req),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_entry  (queue_req)
    );

    radf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (queue_valid),
        .req_ready     (queue_ready),
        .req           (queue_req),
        .node_address  (node_addr_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ hw/rtl/radf_checker.sv @@
// Port-level checker for the register datagram framer, bound to the top level.
module radf_checker
    import radf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [BYTE_W-1:0]    m_axis_tdata,
    input logic                 m_axis_tlast
);

    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic             m_accept;

    assign m_accept = m_axis_tvalid && m_axis_tready;
    assign pos_next = m_accept ? (m_axis_tlast ? '0 : pos_reg + 1'b1) : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    a_sync_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_accept && pos_reg == IDX_SYNC |-> m_axis_tdata == SYNC_BYTE)
        else $error("datagram does not open with the sync byte");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_accept && m_axis_tlast |-> pos_reg == READ_LAST_IDX || pos_reg == WRITE_LAST_IDX)
        else $error("datagram closed at a wrong length");

    a_max_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_accept && pos_reg == WRITE_LAST_IDX |-> m_axis_tlast)
        else $error("datagram runs past eight bytes");

endmodule

bind register_access_datagram_framer radf_checker u_radf_checker (.*);

@@ tb/tb.sv @@
// Testbench for the register access datagram framer: directed and random requests, byte checks.
`timescale 1ns / 100ps

module tb;
    import radf_pkg::*;

    typedef enum logic {
        REQ_READ  = 1'b0,
        REQ_WRITE = 1'b1
    } req_kind_t;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
    } frame_byte_t;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [BYTE_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [BYTE_W-1:0]    cfg_data;

    frame_byte_t       pending_bytes[$];
    logic [BYTE_W-1:0] node_addr_shadow;
    int                tx_idle_pct;
    int                rx_idle_pct;
    bit                hold_req;
    int                hold_left;
    int                error_count;
    int                cycle_count;
    int                read_count;
    int                write_count;
    int                byte_count;
    int                cfg_count;

    register_access_datagram_framer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [BYTE_W-1:0] crc8_lsb_first(input logic [BYTE_W-1:0] crc,
                                                         input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        logic              fb;
        c = crc;
        for (int j = 0; j < BYTE_W; j++)
        begin
            fb = c[BYTE_W-1] ^ b[j];
            c  = c << 1;
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic predict_datagram(input req_kind_t kind, input logic [ADDR_W-1:0] addr,
                                    input logic [DATA_W-1:0] data);
        logic [BYTE_W-1:0] frame[8];
        logic [BYTE_W-1:0] crc;
        frame_byte_t       fb;
        int                n;
        frame[0] = SYNC_BYTE;
        frame[1] = node_addr_shadow;
        if (kind == REQ_WRITE)
        begin
            frame[2] = {1'b0, addr} | WRITE_FLAG;
            frame[3] = data[31:24];
            frame[4] = data[23:16];
            frame[5] = data[15:8];
            frame[6] = data[7:0];
            n = 8;
            write_count++;
        end
        else
        begin
            frame[2] = {1'b0, addr};
            n = 4;
            read_count++;
        end
        crc = '0;
        for (int k = 0; k < n - 1; k++)
        begin
            crc = crc8_lsb_first(crc, frame[k]);
        end
        frame[n-1] = crc;
        for (int k = 0; k < n; k++)
        begin
            fb.value = frame[k];
            fb.last  = (k == n - 1);
            pending_bytes.push_back(fb);
        end
    endtask

    // Call at a rising edge; leaves valid high after the transaction.
    task automatic send_request(input req_kind_t kind, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] data);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, data, addr};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predict_datagram(kind, addr, data);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_address(input logic [BYTE_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        node_addr_shadow = value;
        cfg_count++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_request();
        req_kind_t         kind;
        logic [DATA_W-1:0] data;
        kind = req_kind_t'($urandom_range(1));
        case ($urandom_range(7))
            0: data = '0;
            1: data = '1;
            default: data = $urandom;
        endcase
        send_request(kind, ADDR_W'($urandom_range(127)), data);
    endtask

    task automatic test_directed();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_request(REQ_READ,  7'h00, 32'h0000_0000);
        send_request(REQ_WRITE, 7'h00, 32'h0000_0000);
        send_request(REQ_READ,  7'h7F, 32'hFFFF_FFFF);
        send_request(REQ_WRITE, 7'h7F, 32'hFFFF_FFFF);
        send_request(REQ_WRITE, 7'h55, 32'h8000_0001);
        send_request(REQ_WRITE, 7'h2A, 32'h1234_5678);
        send_request(REQ_READ,  7'h6C, 32'hA5A5_A5A5);
        send_request(REQ_WRITE, 7'h01, 32'h0000_0080);
        write_node_address(8'hFF);
        send_request(REQ_READ,  7'h00, 32'h5A5A_5A5A);
        send_request(REQ_WRITE, 7'h7F, 32'h0000_0000);
        send_request(REQ_WRITE, 7'h40, 32'hFFFF_FFFF);
        send_request(REQ_READ,  7'h7F, 32'h0000_0000);
        send_request(REQ_WRITE, 7'h33, 32'hDEAD_BEEF);
        write_node_address(8'h01);
        send_request(REQ_READ,  7'h15, 32'h0000_0000);
        send_request(REQ_WRITE, 7'h6A, 32'h7FFF_FFFE);
    endtask

    task automatic test_random(input int n, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < n; i++)
        begin
            send_random_request();
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
        for (int i = 0; i < 14; i++)
        begin
            send_random_request();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, actual tdata=%02h tlast=%0b",
                         $time, m_axis_tdata, m_axis_tlast);
                error_count++;
            end
            else
            begin
                frame_byte_t exp_byte;
                exp_byte = pending_bytes.pop_front();
                byte_count++;
                if (m_axis_tdata !== exp_byte.value)
                begin
                    $display("%0t: tdata mismatch: expected %02h, actual %02h",
                             $time, exp_byte.value, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tlast !== exp_byte.last)
                begin
                    $display("%0t: tlast mismatch: expected %0b, actual %0b",
                             $time, exp_byte.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, pending_bytes.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        node_addr_shadow = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b0;
        error_count = 0;
        cycle_count = 0;
        read_count  = 0;
        write_count = 0;
        byte_count  = 0;
        cfg_count   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_node_address(8'hFF);
        test_random(85, 19, 83);
        write_node_address(BYTE_W'($urandom_range(255)));
        test_random(85, 83, 19);
        write_node_address(8'h00);
        test_random(85, 0, 0);
        write_node_address(BYTE_W'($urandom_range(255)));
        test_backpressure();
        s_axis_tvalid <= 1'b0;
        wait_drained();

        $display("tb: %0d reads and %0d writes framed, %0d bytes checked, %0d node writes",
                 read_count, write_count, byte_count, cfg_count);
        $display("tb: covered field extremes, idle and stall mixes, and a long output hold-off");
        if (error_count == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
